[design/asws_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asws_pkg
// Shared widths, constants, register indexes, state types and the request
// and response bundles of the power search unit.
// ----------------------------------------------------------------------------
package asws_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int HEAD_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int NBE_W      = HEAD_W + 1;

	localparam int PKT_W   = 16;
	localparam int CNT_W   = 16;
	localparam int TOTAL_W = 32;
	localparam int VAL_W   = 44;
	localparam int SUM_W   = 50;
	localparam int EST_W   = 51;
	localparam int PROD_W  = 45;
	localparam int NB_W    = 7;
	localparam int G_W     = 32;
	localparam int K_W     = 13;
	localparam int Q_W     = 64;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_SIZE      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKS_IN_USE   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_GROWTH_FRACTION = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_K         = 3'd3;

	localparam logic [CNT_W-1:0] RST_BLOCK_SIZE      = 16'd100;
	localparam logic [NB_W-1:0]  RST_BLOCKS_IN_USE   = 7'd10;
	localparam logic [G_W-1:0]   RST_GROWTH_FRACTION = 32'd214748365;
	localparam logic [K_W-1:0]   RST_SCALE_K         = 13'd40;

	localparam logic [G_W-1:0] GROWTH_MIN = 32'd4194304;
	localparam logic [K_W-1:0] SCALE_MAX  = 13'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_UPDATE,
		ST_SCALE,
		ST_EMIT
	} st_t;

	typedef enum logic [2:0] {
		PW_IDLE,
		PW_MUL_HI,
		PW_MUL_LO,
		PW_STEP,
		PW_FIN_HI,
		PW_FIN_LO,
		PW_FIN_ADD,
		PW_DONE
	} pw_st_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] y;
		logic [G_W-1:0]     g;
		logic [K_W-1:0]     k;
	} pow_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] value;
	} pow_rsp_t;

endpackage
`default_nettype wire

[design/asws_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asws_if
// Valid/ready channels: packet input, estimate output, register writes.
// ----------------------------------------------------------------------------
interface asws_in_if;
	logic                        valid;
	logic                        ready;
	logic [asws_pkg::PKT_W-1:0]  packet_size;

	modport source (output valid, output packet_size, input ready);
	modport sink   (input valid, input packet_size, output ready);
endinterface

interface asws_out_if;
	logic                        valid;
	logic                        ready;
	logic [asws_pkg::EST_W-1:0]  estimate_units;
	logic [asws_pkg::CNT_W-1:0]  window_shortfall;

	modport source (output valid, output estimate_units, output window_shortfall,
		input ready);
	modport sink   (input valid, input estimate_units, input window_shortfall,
		output ready);
endinterface

interface asws_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [asws_pkg::CFG_ADDR_W-1:0]  addr;
	logic [asws_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

[design/asws_ring_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asws_ring_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module asws_ring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 44
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                           wdata,
	input  wire                                        re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/asws_pow.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asws_pow
// Block value unit: largest power p of (1+g) in Q32 with p <= y, then
// floor(p*k). One shared 32x32 multiplier, one half-product per cycle.
// ----------------------------------------------------------------------------
module asws_pow (
	input  wire                 clk,
	input  wire                 arst_n,
	input  asws_pkg::pow_req_t  req,
	output asws_pkg::pow_rsp_t  rsp
);

	asws_pkg::pw_st_t state_q, state_d;

	logic [asws_pkg::Q_W-1:0]   p_q;
	logic [asws_pkg::Q_W-1:0]   rem_q;
	logic [asws_pkg::Q_W-1:0]   prod_h_q;
	logic [asws_pkg::Q_W-1:0]   prod_l_q;
	logic [asws_pkg::G_W-1:0]   g_q;
	logic [asws_pkg::K_W-1:0]   k_q;
	logic [asws_pkg::VAL_W-1:0] value_q;

	logic [31:0]                mul_a;
	logic [31:0]                mul_b;
	logic [asws_pkg::Q_W-1:0]   prod;
	logic [asws_pkg::Q_W-1:0]   inc;
	logic                       stop;

	assign mul_a = (state_q == asws_pkg::PW_MUL_LO || state_q == asws_pkg::PW_FIN_LO)
		? p_q[31:0] : p_q[63:32];
	assign mul_b = (state_q == asws_pkg::PW_FIN_HI || state_q == asws_pkg::PW_FIN_LO)
		? {{(32 - asws_pkg::K_W){1'b0}}, k_q} : g_q;
	assign prod  = mul_a * mul_b;
	assign inc   = prod_h_q + {32'd0, prod_l_q[63:32]};
	// rem_q tracks y*2^32 - p
	assign stop  = inc > rem_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			asws_pkg::PW_IDLE: begin
				if (req.start) begin
					state_d = (req.y == '0) ? asws_pkg::PW_DONE : asws_pkg::PW_MUL_HI;
				end
			end
			asws_pkg::PW_MUL_HI:  state_d = asws_pkg::PW_MUL_LO;
			asws_pkg::PW_MUL_LO:  state_d = asws_pkg::PW_STEP;
			asws_pkg::PW_STEP:    state_d = stop ? asws_pkg::PW_FIN_HI : asws_pkg::PW_MUL_HI;
			asws_pkg::PW_FIN_HI:  state_d = asws_pkg::PW_FIN_LO;
			asws_pkg::PW_FIN_LO:  state_d = asws_pkg::PW_FIN_ADD;
			asws_pkg::PW_FIN_ADD: state_d = asws_pkg::PW_DONE;
			asws_pkg::PW_DONE:    state_d = asws_pkg::PW_IDLE;
			default:              state_d = asws_pkg::PW_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == asws_pkg::PW_DONE);
		rsp.value = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asws_pkg::PW_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			asws_pkg::PW_IDLE: begin
				if (req.start) begin
					g_q     <= req.g;
					k_q     <= req.k;
					p_q     <= {32'd1, 32'd0};
					rem_q   <= {req.y - 32'd1, 32'd0};
					value_q <= '0;
				end
			end
			asws_pkg::PW_MUL_HI, asws_pkg::PW_FIN_HI: begin
				prod_h_q <= prod;
			end
			asws_pkg::PW_MUL_LO, asws_pkg::PW_FIN_LO: begin
				prod_l_q <= prod;
			end
			asws_pkg::PW_STEP: begin
				if (!stop) begin
					p_q   <= p_q + inc;
					rem_q <= rem_q - inc;
				end
			end
			asws_pkg::PW_FIN_ADD: begin
				value_q <= inc[asws_pkg::VAL_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[design/approx_sliding_window_sum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// approx_sliding_window_sum
// Approximate sliding-window sum over packet sizes with rounded block values.
// ----------------------------------------------------------------------------
// Every packet beat yields one estimate beat: the ring sum plus the open
// block total times k, and the item count of the open block. A packet that
// does not close a block passes through accept, scale multiply and output
// load. A packet that closes a block also runs the power search in
// asws_pow: each growth step runs a high and a low half-product on its
// single multiplier and an update, about ln(y)/ln(1+g) steps for block
// total y, plus the step that ends the search; around them run accept,
// search start, final scaling, ring read-modify-write and output. A zero
// block total skips the search. A pending estimate beat holds the next
// packet only when the next result is ready to load.
// Ring entries reset to empty through per-entry valid flags; there is no
// clearing pass. Register writes are taken at any time but belong between
// items.
// ----------------------------------------------------------------------------
module approx_sliding_window_sum (
	input  wire          clk,
	input  wire          arst_n,
	asws_in_if.sink      packets,
	asws_out_if.source   estimates,
	asws_cfg_if.sink     cfg
);

	asws_pkg::st_t state_q, state_d;

	logic [asws_pkg::CNT_W-1:0]   block_size_q;
	logic [asws_pkg::NB_W-1:0]    blocks_q;
	logic [asws_pkg::G_W-1:0]     growth_q;
	logic [asws_pkg::K_W-1:0]     scale_q;

	logic [asws_pkg::HEAD_W-1:0]  head_q;
	logic [asws_pkg::SUM_W-1:0]   sum_q;
	logic [asws_pkg::TOTAL_W-1:0] open_total_q;
	logic [asws_pkg::CNT_W-1:0]   open_count_q;
	logic [asws_pkg::NUM_BLOCKS-1:0] valid_q;
	logic [asws_pkg::PROD_W-1:0]  prod_q;

	logic [asws_pkg::EST_W-1:0]   est_q;
	logic [asws_pkg::CNT_W-1:0]   short_q;
	logic                         out_valid_q;

	logic [asws_pkg::CNT_W-1:0]   bs_eff;
	logic [asws_pkg::NBE_W-1:0]   nb_eff;
	logic [asws_pkg::G_W-1:0]     g_eff;
	logic [asws_pkg::K_W-1:0]     k_eff;
	logic [asws_pkg::TOTAL_W-1:0] new_total;
	logic [asws_pkg::CNT_W-1:0]   new_count;
	logic                         close;
	logic [asws_pkg::HEAD_W-1:0]  head_fix;
	logic [asws_pkg::NBE_W-1:0]   head_inc;
	logic [asws_pkg::VAL_W-1:0]   old_val;
	logic                         accept;
	logic                         load;
	logic                         can_load;
	logic                         ram_we;
	logic                         ram_re;
	logic [asws_pkg::VAL_W-1:0]   ram_rdata;

	asws_pkg::pow_req_t pow_req;
	asws_pkg::pow_rsp_t pow_rsp;

	assign cfg.ready = 1'b1;

	assign bs_eff = (block_size_q == '0) ? asws_pkg::CNT_W'(1) : block_size_q;
	assign nb_eff = (blocks_q == '0) ? asws_pkg::NBE_W'(1)
		: ((32'(blocks_q) > asws_pkg::NUM_BLOCKS) ? asws_pkg::NBE_W'(asws_pkg::NUM_BLOCKS)
		: asws_pkg::NBE_W'(blocks_q));
	assign g_eff  = (growth_q < asws_pkg::GROWTH_MIN) ? asws_pkg::GROWTH_MIN : growth_q;
	assign k_eff  = (scale_q == '0) ? asws_pkg::K_W'(1)
		: ((scale_q > asws_pkg::SCALE_MAX) ? asws_pkg::SCALE_MAX : scale_q);

	assign new_total = open_total_q + asws_pkg::TOTAL_W'(packets.packet_size);
	assign new_count = open_count_q + asws_pkg::CNT_W'(1);
	assign close     = (new_count >= bs_eff) || (new_count == '0);
	assign head_fix  = ({1'b0, head_q} >= nb_eff) ? '0 : head_q;
	assign head_inc  = {1'b0, head_q} + asws_pkg::NBE_W'(1);
	assign old_val   = valid_q[head_q] ? ram_rdata : '0;
	assign can_load  = !out_valid_q || estimates.ready;
	assign accept    = packets.valid && packets.ready;

	always_comb begin
		pow_req.start = (state_q == asws_pkg::ST_START);
		pow_req.y     = open_total_q;
		pow_req.g     = g_eff;
		pow_req.k     = k_eff;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			asws_pkg::ST_IDLE: begin
				if (packets.valid) begin
					state_d = close ? asws_pkg::ST_START : asws_pkg::ST_SCALE;
				end
			end
			asws_pkg::ST_START:  state_d = asws_pkg::ST_WAIT;
			asws_pkg::ST_WAIT: begin
				if (pow_rsp.done) begin
					state_d = asws_pkg::ST_UPDATE;
				end
			end
			asws_pkg::ST_UPDATE: state_d = asws_pkg::ST_SCALE;
			asws_pkg::ST_SCALE:  state_d = asws_pkg::ST_EMIT;
			asws_pkg::ST_EMIT: begin
				if (can_load) begin
					state_d = asws_pkg::ST_IDLE;
				end
			end
			default:             state_d = asws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		packets.ready = (state_q == asws_pkg::ST_IDLE);
		ram_re        = (state_q == asws_pkg::ST_START);
		ram_we        = (state_q == asws_pkg::ST_UPDATE);
		load          = (state_q == asws_pkg::ST_EMIT) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= asws_pkg::RST_BLOCK_SIZE;
			blocks_q     <= asws_pkg::RST_BLOCKS_IN_USE;
			growth_q     <= asws_pkg::RST_GROWTH_FRACTION;
			scale_q      <= asws_pkg::RST_SCALE_K;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				asws_pkg::CFG_BLOCK_SIZE:      block_size_q <= cfg.data[asws_pkg::CNT_W-1:0];
				asws_pkg::CFG_BLOCKS_IN_USE:   blocks_q     <= cfg.data[asws_pkg::NB_W-1:0];
				asws_pkg::CFG_GROWTH_FRACTION: growth_q     <= cfg.data[asws_pkg::G_W-1:0];
				asws_pkg::CFG_SCALE_K:         scale_q      <= cfg.data[asws_pkg::K_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			sum_q        <= '0;
			open_total_q <= '0;
			open_count_q <= '0;
			valid_q      <= '0;
		end else if (accept) begin
			open_total_q <= new_total;
			open_count_q <= new_count;
			if (close) begin
				head_q <= head_fix;
			end
		end else if (state_q == asws_pkg::ST_UPDATE) begin
			sum_q           <= sum_q + asws_pkg::SUM_W'(pow_rsp.value)
				- asws_pkg::SUM_W'(old_val);
			valid_q[head_q] <= 1'b1;
			head_q          <= (head_inc >= nb_eff) ? '0 : head_inc[asws_pkg::HEAD_W-1:0];
			open_total_q    <= '0;
			open_count_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == asws_pkg::ST_SCALE) begin
			prod_q <= asws_pkg::PROD_W'(open_total_q) * asws_pkg::PROD_W'(k_eff);
		end
		if (load) begin
			est_q   <= asws_pkg::EST_W'(sum_q) + asws_pkg::EST_W'(prod_q);
			short_q <= open_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (estimates.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign estimates.valid            = out_valid_q;
	assign estimates.estimate_units   = est_q;
	assign estimates.window_shortfall = short_q;

	asws_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pow_req),
		.rsp    (pow_rsp)
	);

	asws_ring_ram #(
		.DEPTH (asws_pkg::NUM_BLOCKS),
		.WIDTH (asws_pkg::VAL_W)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (pow_rsp.value),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
